FILE: design/rci_pkg.sv
// Package for the ray/cone intersection unit.
// Holds widths, register indexes, payload types and the fixed-point helpers.
// No dependencies.
package rci_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CW  = 32;
  localparam int AXW = 18;
  localparam int KW  = 31;

  localparam int VW  = 63;
  localparam int HW  = (VW - 1) / 2;
  localparam int PW  = 2 * HW;
  localparam int SW  = 4 * HW;

  localparam int NW  = VW - 1 + FRAC_BITS;
  localparam int SQB = (NW + 1) / 2;
  localparam int TW  = 2 * SQB + 1;
  localparam int DNW = VW + FRAC_BITS;
  localparam int QB  = CW;

  localparam int NL1 = 15;
  localparam int NDOT = 5;
  localparam int TOP_STAGES = 20;
  localparam int ROOT_STAGES = SQB + QB + 5;

  localparam int IXW = 3;
  typedef logic [IXW-1:0] cfg_ix_t;
  localparam cfg_ix_t REG_APEX_X = 3'd0;
  localparam cfg_ix_t REG_APEX_Y = 3'd1;
  localparam cfg_ix_t REG_APEX_Z = 3'd2;
  localparam cfg_ix_t REG_AXIS_X = 3'd3;
  localparam cfg_ix_t REG_AXIS_Y = 3'd4;
  localparam cfg_ix_t REG_AXIS_Z = 3'd5;
  localparam cfg_ix_t REG_SLOPE  = 3'd6;

  localparam logic signed [AXW-1:0] AXIS_Z_RST = AXW'(65536);
  localparam logic [KW-1:0]         SLOPE_RST  = KW'(131072);
  localparam logic signed [CW-1:0]  NOHIT_DIST = -(CW'(1) << FRAC_BITS);

  typedef logic signed [VW-1:0] sval_t;
  typedef logic [PW-1:0] umag_t;

  localparam umag_t SATM = '1;
  localparam sval_t SATV = sval_t'({1'b0, SATM});

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] distance;
    logic                 tangent;
  } out_t;

  typedef struct packed {
    logic           neg;
    logic [PW-1:0]  p00;
    logic [PW-1:0]  p01;
    logic [PW-1:0]  p10;
    logic [PW-1:0]  p11;
  } pp_t;

  typedef struct packed {
    logic          neg;
    logic [SW-1:0] sum;
  } psum_t;

  typedef struct packed {
    logic  valid;
    sval_t a;
    sval_t b;
    sval_t disc;
  } quad_t;

  function automatic umag_t vmag(sval_t v);
    logic [VW-1:0] m;
    m = v[VW-1] ? -v : v;
    return m[PW-1:0];
  endfunction

  // Four half-width partial products of the operand magnitudes.
  function automatic pp_t mul_pp(sval_t x, sval_t y);
    pp_t p;
    umag_t xm;
    umag_t ym;
    xm = vmag(x);
    ym = vmag(y);
    p.neg = x[VW-1] ^ y[VW-1];
    p.p00 = PW'(xm[HW-1:0]) * PW'(ym[HW-1:0]);
    p.p01 = PW'(xm[HW-1:0]) * PW'(ym[PW-1:HW]);
    p.p10 = PW'(xm[PW-1:HW]) * PW'(ym[HW-1:0]);
    p.p11 = PW'(xm[PW-1:HW]) * PW'(ym[PW-1:HW]);
    return p;
  endfunction

  function automatic psum_t mul_sum(pp_t p);
    psum_t s;
    s.neg = p.neg;
    s.sum = SW'(p.p00) + (SW'(p.p01) << HW) + (SW'(p.p10) << HW) + (SW'(p.p11) << PW);
    return s;
  endfunction

  // Drops the fraction bits, truncating toward zero, and saturates.
  function automatic sval_t mul_fin(psum_t s);
    logic [SW-1:0] sh;
    sval_t r;
    sh = s.sum >> FRAC_BITS;
    if (sh > SW'(SATM)) begin
      r = SATV;
    end else begin
      r = sval_t'({1'b0, sh[PW-1:0]});
    end
    return s.neg ? -r : r;
  endfunction

  function automatic sval_t sadd(sval_t x, sval_t y);
    logic signed [VW:0] s;
    s = $signed({x[VW-1], x}) + $signed({y[VW-1], y});
    if (s > $signed({2'b00, SATM})) begin
      return SATV;
    end else if (s < -$signed({2'b00, SATM})) begin
      return -SATV;
    end
    return s[VW-1:0];
  endfunction

endpackage

FILE: design/rci_if.sv
// Handshake channels of the ray/cone intersection unit.
// Depends on rci_pkg for the payload types.
interface rci_in_if import rci_pkg::*;;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rci_out_if import rci_pkg::*;;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rci_cfg_if import rci_pkg::*;;
  logic          valid;
  logic          ready;
  cfg_ix_t       index;
  logic [CW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/rci_root.sv
// Back half of the ray/cone intersection pipeline: square root, root selection,
// division and the registered result. Depends on rci_pkg and rci_if.
module rci_root import rci_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  quad_t     quad,
  output logic      adv,
  rci_out_if.source hit_out
);

  typedef struct packed {
    logic [TW-1:0]  rem;
    logic [SQB-1:0] root;
  } sq_t;

  typedef struct packed {
    logic  nosol;
    logic  zero;
    sval_t a;
    sval_t b;
  } side_t;

  typedef struct packed {
    logic [VW-1:0] rem;
    logic [QB-1:0] q;
    logic [QB-1:0] low;
    logic [VW-1:0] d;
    logic          nosol;
    logic          zero;
    logic          negq;
    logic          big;
  } dv_t;

  function automatic sq_t sq_step(sq_t x, int bit_ix);
    sq_t y;
    logic [TW-1:0] trial;
    trial = (TW'(x.root) << (bit_ix + 1)) | (TW'(1) << (2 * bit_ix));
    y = x;
    if (x.rem >= trial) begin
      y.rem = x.rem - trial;
      y.root = x.root | (SQB'(1) << bit_ix);
    end
    return y;
  endfunction

  function automatic dv_t dv_step(dv_t x);
    dv_t y;
    logic [VW:0] r;
    logic take;
    y = x;
    r = {x.rem, x.low[QB-1]};
    take = r >= {1'b0, x.d};
    if (take) begin
      r = r - {1'b0, x.d};
    end
    y.rem = r[VW-1:0];
    y.low = x.low << 1;
    y.q = {x.q[QB-2:0], take};
    return y;
  endfunction

  logic [ROOT_STAGES-1:0] rvld;
  sq_t   sq [0:SQB];
  side_t sd [0:SQB];
  logic signed [VW:0] num1;
  side_t sd1;
  logic [VW-1:0] nm2;
  logic [VW-1:0] d2;
  logic negq2;
  side_t sd2;
  dv_t dv [0:QB];

  logic signed [VW:0] bx;
  logic signed [VW:0] sx;
  logic signed [VW:0] num_next;
  logic signed [VW:0] nabs;
  logic [DNW-1:0] dvn;
  logic [QB:0] qm;
  logic [QB:0] lim;
  out_t res;

  assign hit_out.valid = rvld[ROOT_STAGES-1];
  assign adv = ~hit_out.valid | hit_out.ready;

  always_comb begin
    bx = (VW + 1)'(sd[SQB].b);
    sx = (VW + 1)'(sq[SQB].root);
    num_next = (sd[SQB].a > 0) ? (-bx - sx) : (-bx + sx);
    nabs = num1[VW] ? -num1 : num1;
    dvn = {nm2, {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    qm = dv[QB].big ? {1'b1, {QB{1'b0}}} : {1'b0, dv[QB].q};
    lim = (QB + 1)'(1) << (QB - 1);
    res.hit = ~dv[QB].nosol;
    res.tangent = ~dv[QB].nosol & dv[QB].zero;
    if (dv[QB].nosol) begin
      res.distance = NOHIT_DIST;
    end else if (dv[QB].negq) begin
      res.distance = (qm > lim) ? lim[CW-1:0] : -qm[CW-1:0];
    end else begin
      res.distance = (qm >= lim) ? ~lim[CW-1:0] : qm[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld <= '0;
    end else if (adv) begin
      rvld <= {rvld[ROOT_STAGES-2:0], quad.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].rem <= TW'({quad.disc[VW-2:0], {FRAC_BITS{1'b0}}});
      sq[0].root <= '0;
      sd[0].nosol <= quad.disc[VW-1] | (quad.a == '0);
      sd[0].zero <= quad.disc == '0;
      sd[0].a <= quad.a;
      sd[0].b <= quad.b;
      for (int j = 0; j < SQB; j++) begin
        sq[j+1] <= sq_step(sq[j], SQB - 1 - j);
        sd[j+1] <= sd[j];
      end

      num1 <= num_next;
      sd1 <= sd[SQB];

      nm2 <= nabs[VW-1:0];
      d2 <= {vmag(sd1.a), 1'b0};
      negq2 <= num1[VW] ^ sd1.a[VW-1];
      sd2 <= sd1;

      dv[0].rem <= VW'(dvn[DNW-1:QB]);
      dv[0].low <= dvn[QB-1:0];
      dv[0].q <= '0;
      dv[0].d <= d2;
      dv[0].big <= VW'(dvn[DNW-1:QB]) >= d2;
      dv[0].negq <= negq2;
      dv[0].nosol <= sd2.nosol;
      dv[0].zero <= sd2.zero;
      for (int k = 0; k < QB; k++) begin
        dv[k+1] <= dv_step(dv[k]);
      end

      hit_out.data <= res;
    end
  end

endmodule

FILE: design/ray_cone_intersect_unit.sv
// Top level of the ray/cone intersection unit: configuration registers and the
// coefficient pipeline. Depends on rci_pkg, rci_if and rci_root.
//
// Tests one ray per transaction against an infinite double cone set by the apex,
// unit axis and slope factor registers, and returns hit, the smaller root as a
// saturated Q16.16 distance, and a tangent flag. The unit is fully pipelined and
// takes a new ray every cycle. Its stages are the dot products and quadratic
// coefficients, the one-bit-per-stage square root, the one-bit-per-stage
// divider, and the selection and output stages. When the result is not taken
// the whole pipeline holds. Write the registers only while idle.
module ray_cone_intersect_unit import rci_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rci_cfg_if.sink   cfg,
  rci_in_if.sink    ray_in,
  rci_out_if.source hit_out
);

  typedef struct packed {
    sval_t dd;
    sval_t dl;
    sval_t ll;
  } dots_t;

  typedef struct packed {
    sval_t a;
    sval_t b;
  } pair_t;

  logic signed [CW-1:0]  apex_x;
  logic signed [CW-1:0]  apex_y;
  logic signed [CW-1:0]  apex_z;
  logic signed [AXW-1:0] axis_x;
  logic signed [AXW-1:0] axis_y;
  logic signed [AXW-1:0] axis_z;
  logic [KW-1:0]         slope_factor;

  logic adv;
  logic [TOP_STAGES-1:0] vld;
  quad_t quad;

  in_t   rin;
  sval_t lv [0:2];
  sval_t dv [0:2];
  sval_t axv [0:2];
  sval_t kv;
  sval_t m1x [0:NL1-1];
  sval_t m1y [0:NL1-1];
  pp_t   p1 [0:NL1-1];
  psum_t q1 [0:NL1-1];
  sval_t r1 [0:NL1-1];
  sval_t dq [0:NDOT-1];
  sval_t dr [0:NDOT-1];
  sval_t dot [0:NDOT-1];
  pp_t   p2 [0:2];
  psum_t q2 [0:2];
  sval_t r2 [0:2];
  pp_t   p3 [0:2];
  psum_t q3 [0:2];
  sval_t r3 [0:2];
  dots_t dk [0:5];
  sval_t a13;
  sval_t hb13;
  sval_t c13;
  sval_t a14;
  sval_t b14;
  sval_t c14;
  pp_t   p4 [0:1];
  psum_t q4 [0:1];
  sval_t r4 [0:1];
  pair_t ab [0:2];
  sval_t ac4;
  sval_t bb18;
  pair_t ab18;
  sval_t disc19;
  pair_t ab19;

  assign cfg.ready = 1'b1;
  assign ray_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      apex_x <= '0;
      apex_y <= '0;
      apex_z <= '0;
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= AXIS_Z_RST;
      slope_factor <= SLOPE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_APEX_X: apex_x <= cfg.data;
        REG_APEX_Y: apex_y <= cfg.data;
        REG_APEX_Z: apex_z <= cfg.data;
        REG_AXIS_X: axis_x <= cfg.data[AXW-1:0];
        REG_AXIS_Y: axis_y <= cfg.data[AXW-1:0];
        REG_AXIS_Z: axis_z <= cfg.data[AXW-1:0];
        REG_SLOPE:  slope_factor <= cfg.data[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    axv[0] = sval_t'(axis_x);
    axv[1] = sval_t'(axis_y);
    axv[2] = sval_t'(axis_z);
    kv = sval_t'(slope_factor);
    for (int i = 0; i < 3; i++) begin
      m1x[i] = dv[i];
      m1y[i] = dv[i];
      m1x[3+i] = dv[i];
      m1y[3+i] = lv[i];
      m1x[6+i] = lv[i];
      m1y[6+i] = lv[i];
      m1x[9+i] = dv[i];
      m1y[9+i] = axv[i];
      m1x[12+i] = lv[i];
      m1y[12+i] = axv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOP_STAGES-2:0], ray_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rin <= ray_in.data;

      lv[0] <= sval_t'(rin.origin_x) - sval_t'(apex_x);
      lv[1] <= sval_t'(rin.origin_y) - sval_t'(apex_y);
      lv[2] <= sval_t'(rin.origin_z) - sval_t'(apex_z);
      dv[0] <= sval_t'(rin.dir_x);
      dv[1] <= sval_t'(rin.dir_y);
      dv[2] <= sval_t'(rin.dir_z);

      for (int i = 0; i < NL1; i++) begin
        p1[i] <= mul_pp(m1x[i], m1y[i]);
        q1[i] <= mul_sum(p1[i]);
        r1[i] <= mul_fin(q1[i]);
      end

      for (int j = 0; j < NDOT; j++) begin
        dq[j] <= sadd(r1[3*j], r1[3*j+1]);
        dr[j] <= r1[3*j+2];
        dot[j] <= sadd(dq[j], dr[j]);
      end

      // The dot products are ordered D.D, D.L, L.L, D.N, L.N.
      p2[0] <= mul_pp(dot[3], dot[3]);
      p2[1] <= mul_pp(dot[3], dot[4]);
      p2[2] <= mul_pp(dot[4], dot[4]);
      dk[0] <= {dot[0], dot[1], dot[2]};
      for (int i = 1; i < 6; i++) begin
        dk[i] <= dk[i-1];
      end

      for (int i = 0; i < 3; i++) begin
        q2[i] <= mul_sum(p2[i]);
        r2[i] <= mul_fin(q2[i]);
        p3[i] <= mul_pp(kv, r2[i]);
        q3[i] <= mul_sum(p3[i]);
        r3[i] <= mul_fin(q3[i]);
      end

      a13 <= sadd(dk[5].dd, -r3[0]);
      hb13 <= sadd(dk[5].dl, -r3[1]);
      c13 <= sadd(dk[5].ll, -r3[2]);

      a14 <= a13;
      c14 <= c13;
      b14 <= sadd(hb13, hb13);

      p4[0] <= mul_pp(a14, c14);
      p4[1] <= mul_pp(b14, b14);
      ab[0] <= {a14, b14};
      for (int i = 0; i < 2; i++) begin
        q4[i] <= mul_sum(p4[i]);
        r4[i] <= mul_fin(q4[i]);
      end
      ab[1] <= ab[0];
      ab[2] <= ab[1];

      ac4 <= sadd(sadd(r4[0], r4[0]), sadd(r4[0], r4[0]));
      bb18 <= r4[1];
      ab18 <= ab[2];

      disc19 <= sadd(bb18, -ac4);
      ab19 <= ab18;
    end
  end

  always_comb begin
    quad.valid = vld[TOP_STAGES-1];
    quad.a = ab19.a;
    quad.b = ab19.b;
    quad.disc = disc19;
  end

  rci_root u_root (
    .clk     (clk),
    .rst     (rst),
    .quad    (quad),
    .adv     (adv),
    .hit_out (hit_out)
  );

endmodule

FILE: sim/ray_cone_intersect_unit_tb.sv
// Self-checking testbench for ray_cone_intersect_unit: directed rays, then random rays under
// several cone settings, with random idling on both channels and one long output hold-off.
// Depends on rci_pkg and the rci_in_if, rci_out_if and rci_cfg_if interfaces of the design.
module ray_cone_intersect_unit_tb;
  import rci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT64 = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam int ONE = 65536;
  localparam int RANDOM_PHASES = 6;
  localparam int RAYS_PER_PHASE = 225;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    in_t  ray;
    bit   typed;
    out_t want;
  } ray_row_t;

  logic clk;
  logic rst;
  rci_cfg_if cfg_ch();
  rci_in_if  ray_ch();
  rci_out_if hit_ch();

  longint apex_x, apex_y, apex_z, axis_x, axis_y, axis_z, slope;
  out_t   pending_hits[$];
  ray_row_t rows[$];
  int     errors;
  int     rays_sent;
  int     idle_cycles;
  bit     long_hold_done;

  ray_cone_intersect_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch.sink),
    .ray_in  (ray_ch.sink),
    .hit_out (hit_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint sat_add(longint x, longint y);
    longint s;
    s = x + y;
    if (s > SAT64) return SAT64;
    if (s < -SAT64) return -SAT64;
    return s;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    logic [127:0] p;
    longint r;
    p = ({64'd0, magn(x)} * {64'd0, magn(y)}) >> FRAC_BITS;
    r = (p > 128'(SAT64)) ? SAT64 : longint'(p[63:0]);
    return ((x < 0) != (y < 0)) ? -r : r;
  endfunction

  function automatic longint dot(longint x0, longint x1, longint x2,
                                 longint y0, longint y1, longint y2);
    return sat_add(sat_add(fx_mul(x0, y0), fx_mul(x1, y1)), fx_mul(x2, y2));
  endfunction

  function automatic longint fx_sqrt(longint v);
    logic [127:0] vv;
    logic [127:0] r;
    logic [127:0] c;
    vv = {64'd0, v} << FRAC_BITS;
    r = '0;
    for (int b = 44; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= vv) r = c;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic out_t cone_hit(in_t ray);
    longint dx, dy, dz, lx, ly, lz, dd, dl, ll, dn, ln, a, hb, b, c, ac, ac2, disc, s, num;
    logic [127:0] q;
    longint unsigned qm;
    out_t o;
    dx = longint'(ray.dir_x);
    dy = longint'(ray.dir_y);
    dz = longint'(ray.dir_z);
    lx = longint'(ray.origin_x) - apex_x;
    ly = longint'(ray.origin_y) - apex_y;
    lz = longint'(ray.origin_z) - apex_z;
    dd = dot(dx, dy, dz, dx, dy, dz);
    dl = dot(dx, dy, dz, lx, ly, lz);
    ll = dot(lx, ly, lz, lx, ly, lz);
    dn = dot(dx, dy, dz, axis_x, axis_y, axis_z);
    ln = dot(lx, ly, lz, axis_x, axis_y, axis_z);
    a = sat_add(dd, -fx_mul(slope, fx_mul(dn, dn)));
    hb = sat_add(dl, -fx_mul(slope, fx_mul(dn, ln)));
    b = sat_add(hb, hb);
    c = sat_add(ll, -fx_mul(slope, fx_mul(ln, ln)));
    ac = fx_mul(a, c);
    ac2 = sat_add(ac, ac);
    disc = sat_add(fx_mul(b, b), -sat_add(ac2, ac2));
    if (disc < 0 || a == 0) begin
      o.hit = 1'b0;
      o.distance = NOHIT_DIST;
      o.tangent = 1'b0;
      return o;
    end
    s = fx_sqrt(disc);
    num = a > 0 ? -b - s : -b + s;
    q = ({64'd0, magn(num)} << FRAC_BITS) / {64'd0, magn(a) << 1};
    qm = (q >= 128'h1_0000_0000) ? 64'h1_0000_0000 : q[63:0];
    if ((num < 0) != (a < 0)) begin
      o.distance = (qm > 64'h8000_0000) ? 32'sh8000_0000 : CW'(-longint'(qm));
    end else begin
      o.distance = (qm > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : CW'(qm);
    end
    o.hit = 1'b1;
    o.tangent = (disc == 0);
    return o;
  endfunction

  function automatic in_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    in_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    return r;
  endfunction

  function automatic out_t mk_hit(bit h, int d, bit t);
    out_t o;
    o.hit = h;
    o.distance = d;
    o.tangent = t;
    return o;
  endfunction

  function automatic int coord();
    if ($urandom_range(0, 4) == 0) return int'($urandom());
    return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic in_t random_ray();
    return mk_ray(coord(), coord(), coord(), coord(), coord(), coord());
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
  endtask

  task automatic write_reg(cfg_ix_t ix, logic [CW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ix;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (ix)
      REG_APEX_X: apex_x = longint'($signed(val));
      REG_APEX_Y: apex_y = longint'($signed(val));
      REG_APEX_Z: apex_z = longint'($signed(val));
      REG_AXIS_X: axis_x = longint'($signed(val[AXW-1:0]));
      REG_AXIS_Y: axis_y = longint'($signed(val[AXW-1:0]));
      REG_AXIS_Z: axis_z = longint'($signed(val[AXW-1:0]));
      REG_SLOPE:  slope = longint'(val[KW-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_cone(int px, int py, int pz, int nx, int ny, int nz, int k);
    write_reg(REG_APEX_X, px);
    write_reg(REG_APEX_Y, py);
    write_reg(REG_APEX_Z, pz);
    write_reg(REG_AXIS_X, nx);
    write_reg(REG_AXIS_Y, ny);
    write_reg(REG_AXIS_Z, nz);
    write_reg(REG_SLOPE, k);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_ray(in_t ray, bit typed, out_t want);
    int gap;
    ray_ch.valid <= 1'b1;
    ray_ch.data <= ray;
    do @(posedge clk); while (!ray_ch.ready);
    pending_hits.push_back(typed ? want : cone_hit(ray));
    rays_sent++;
    gap = $urandom_range(0, 8);
    if ((rays_sent / 40) % 3 == 2) gap = 0;
    if (gap != 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int axis_val();
    case ($urandom_range(0, 3))
      0: return ONE;
      1: return -ONE;
      2: return 0;
      default: return int'($urandom_range(0, 2 * ONE)) - ONE;
    endcase
  endfunction

  always @(posedge clk) begin
    if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ray_cone_intersect_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int gap;
    out_t want;
    hit_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 8);
      if ((rays_sent / 50) % 4 == 3) gap = 0;
      if (!long_hold_done && rays_sent > 120) begin
        long_hold_done = 1'b1;
        gap = 400;
      end
      if (gap != 0) begin
        hit_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hit_ch.ready <= 1'b1;
      do @(posedge clk); while (!hit_ch.valid);
      if (pending_hits.size() == 0) begin
        report("unexpected transaction", hit_ch.data.distance, 0);
      end else begin
        want = pending_hits.pop_front();
        if (hit_ch.data.hit !== want.hit) report("hit", hit_ch.data.hit, want.hit);
        if (hit_ch.data.distance !== want.distance)
          report("distance", hit_ch.data.distance, want.distance);
        if (hit_ch.data.tangent !== want.tangent)
          report("tangent", hit_ch.data.tangent, want.tangent);
      end
    end
  end

  initial begin
    ray_row_t row;
    out_t none;
    none = mk_hit(1'b0, NOHIT_DIST, 1'b0);
    errors = 0;
    rays_sent = 0;
    long_hold_done = 1'b0;
    apex_x = 0; apex_y = 0; apex_z = 0;
    axis_x = 0; axis_y = 0; axis_z = 65536;
    slope = 131072;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_APEX_X;
    cfg_ch.data = '0;
    ray_ch.valid = 1'b0;
    ray_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0), 1, none});
    rows.push_back('{mk_ray(0, 5 * ONE, 0, ONE, 0, 0), 1, none});
    rows.push_back('{mk_ray(0, 0, -5 * ONE, 0, 0, ONE), 1, mk_hit(1, 5 * ONE, 1)});
    rows.push_back('{mk_ray(0, 0, 0, ONE, 0, 0), 1, mk_hit(1, 0, 1)});
    rows.push_back('{mk_ray(0, 0, 5 * ONE, ONE, 0, 0), 1, mk_hit(1, -5 * ONE, 0)});
    rows.push_back('{mk_ray(5 * ONE, 0, 0, 0, 0, ONE), 1, mk_hit(1, -5 * ONE, 0)});
    rows.push_back('{mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none});
    rows.push_back('{mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none});
    rows.push_back('{mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0, none});
    rows.push_back('{mk_ray(0, 0, 32'h7FFF_FFFF, 1, 0, 0), 0, none});
    rows.push_back('{mk_ray(0, 0, 32'h8000_0000, 0, 1, 0), 0, none});
    rows.push_back('{mk_ray(3 * ONE, ONE, -7 * ONE, 1, 2, ONE), 0, none});
    rows.push_back('{mk_ray(ONE, ONE, 10 * ONE, -ONE, 0, -ONE / 2), 0, none});
    rows.push_back('{mk_ray(-1, -1, -1, -1, -1, -1), 0, none});
    rows.push_back('{mk_ray(1, 1, 1, 1, 1, 1), 0, none});
    rows.push_back('{mk_ray(0, 0, 2 * ONE, ONE, ONE, 0), 0, none});
    rows.push_back('{mk_ray(2 * ONE, 0, 3 * ONE, -ONE, 0, -ONE), 0, none});
    rows.push_back('{mk_ray(0, 4 * ONE, -4 * ONE, 0, -ONE, ONE), 0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_ray(row.ray, row.typed, row.want);
    end
    ray_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_cone(0, 0, 0, 0, 0, ONE, 2 * ONE);
        1: write_cone(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      -ONE, ONE, -ONE, 32'h7FFF_FFFF);
        2: write_cone(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      ONE, -ONE, ONE, ONE);
        default: write_cone(coord(), coord(), coord(), axis_val(), axis_val(), axis_val(),
                            ($urandom_range(0, 3) == 0) ?
                              int'($urandom_range(ONE, 32'h7FFF_FFFF)) :
                              int'($urandom_range(ONE, 8 * ONE)));
      endcase
      for (int n = 0; n < RAYS_PER_PHASE; n++) send_ray(random_ray(), 0, none);
      ray_ch.valid <= 1'b0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (pending_hits.size() != 0) report("results left over", pending_hits.size(), 0);
    if (errors == 0) begin
      $display("ray_cone_intersect_unit regression: pass");
    end else begin
      $display("ray_cone_intersect_unit regression: fail");
    end
    $finish;
  end

endmodule
